FILE: hw/rtl/smp_pkg.sv
// Package with the constants shared by the shuffled minimal-standard generator.
`timescale 1ns / 1ps

package smp_pkg;

  // Generator word width and the Mersenne prime modulus 2^31 - 1.
  localparam int unsigned WORD_W = 31;
  localparam logic [WORD_W-1:0] MODULUS = 31'h7FFF_FFFF;

  // Minimal-standard multiplier and its width.
  localparam int unsigned MULT_W = 15;
  localparam logic [MULT_W-1:0] MULT = 15'd16807;

  // Full product width of one generator step.
  localparam int unsigned PROD_W = WORD_W + MULT_W;

  // Default shuffle table depth and the extra warm-up steps before the fill.
  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned WARMUP_EXTRA = 8;

endpackage

FILE: hw/rtl/smp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module smp_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the read word holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/smp_mulmod.sv
// Generator step unit: registered multiply by 16807, then a Mersenne fold mod 2^31 - 1.
`timescale 1ns / 1ps

module smp_mulmod (
  input  logic                      clk,
  input  logic                      en,
  input  logic [smp_pkg::WORD_W-1:0] operand,
  output logic [smp_pkg::WORD_W-1:0] result
);

  import smp_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [WORD_W:0]   sum;

  // Product register; the fold below reads it combinationally.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(operand) * PROD_W'(MULT);
    end
  end

  // Since 2^31 is 1 mod the modulus, the high part adds onto the low part.
  // The sum stays below twice the modulus, so one subtraction finishes it.
  always_comb begin
    sum = (WORD_W + 1)'(prod[WORD_W-1:0]) + (WORD_W + 1)'(prod[PROD_W-1:WORD_W]);
    if (sum >= (WORD_W + 1)'(MODULUS)) begin
      result = WORD_W'(sum - (WORD_W + 1)'(MODULUS));
    end else begin
      result = sum[WORD_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/smp_slot.sv
// Shuffle slot selection: floor(depth * last / (2^31 - 2 + depth)).
`timescale 1ns / 1ps

module smp_slot #(
  parameter int unsigned TABLE_DEPTH = smp_pkg::TABLE_DEPTH_DEF
) (
  input  logic [smp_pkg::WORD_W-1:0]     last,
  output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

  import smp_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned DW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW = WORD_W + DW;
  localparam int unsigned NW = PW + 1;
  localparam logic [NW-1:0] DIVISOR = NW'(64'h7FFF_FFFE + 64'(TABLE_DEPTH));

  logic [PW-1:0] scaled;
  logic [DW-1:0] q_est;
  logic [NW-1:0] q_back;
  logic [DW-1:0] q;

  // Dividing by 2^31 instead of the divisor overestimates by at most one,
  // so one multiply-back and compare corrects the estimate.
  always_comb begin
    scaled = PW'(last) * PW'(TABLE_DEPTH);
    q_est  = scaled[PW-1:WORD_W];
    q_back = NW'(q_est) * DIVISOR;
    if (q_back > NW'(scaled)) begin
      q = q_est - DW'(1);
    end else begin
      q = q_est;
    end
    if (q >= DW'(TABLE_DEPTH)) begin
      slot = AW'(TABLE_DEPTH - 1);
    end else begin
      slot = q[AW-1:0];
    end
  end

endmodule

FILE: hw/rtl/shuffled_minimal_standard_prng.sv
// Top level of the shuffled minimal-standard pseudo-random generator.
`timescale 1ns / 1ps

// Minimal-standard generator (times 16807 mod 2^31 - 1) behind a shuffle
// table held in a RAM. Each accepted word is a draw or a reseed and gives
// exactly one result word. In a draw on an initialized block, the accept
// cycle reads the chosen slot and starts the multiply, and S_DRAW_WR then
// writes the new generator value back and loads the result. A reseed, and
// the first draw after reset, first run initialization: TABLE_DEPTH + 8
// generator steps through the single multiply-and-fold unit, each in
// S_INIT_MUL then S_INIT_FOLD, and then S_DRAW_RD issues the draw. A
// finished result waits in the output register while the next word is
// accepted; the table write of that next draw holds until the output
// register is free.
module shuffled_minimal_standard_prng #(
  parameter int unsigned TABLE_DEPTH = smp_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic                       operation,
  input  logic [smp_pkg::WORD_W-1:0] seed,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [smp_pkg::WORD_W-1:0] value
);

  import smp_pkg::*;

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned STEPS = TABLE_DEPTH + WARMUP_EXTRA;
  localparam int unsigned SW    = $clog2(STEPS);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_INIT_MUL  = 5'b00010,
    S_INIT_FOLD = 5'b00100,
    S_DRAW_RD   = 5'b01000,
    S_DRAW_WR   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [WORD_W-1:0] gen;
  logic [WORD_W-1:0] last;
  logic [SW-1:0]     step;
  logic [AW-1:0]     slot_reg;

  logic              accept;
  logic              need_init;
  logic [WORD_W-1:0] seed_fix;
  logic              issue;
  logic              mm_en;
  logic [WORD_W-1:0] gen_step;
  logic [AW-1:0]     slot_c;
  logic              out_free;
  logic              init_we;
  logic              draw_we;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_rdata;

  // Handshake and decode of the incoming word.
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign need_init  = operation || (last == '0);
  assign seed_fix   = ((seed == '0) || (seed == MODULUS)) ? WORD_W'(1) : seed;
  assign out_free   = !result_valid || !result_stall;

  // A draw read is issued straight from idle or after initialization.
  assign issue = (accept && !need_init) || (state == S_DRAW_RD);
  assign mm_en = issue || (state == S_INIT_MUL);

  // Table writes: warm-up fill, or the write-back of a draw.
  assign init_we   = (state == S_INIT_FOLD) && (step < SW'(TABLE_DEPTH));
  assign draw_we   = (state == S_DRAW_WR) && out_free;
  assign ram_we    = init_we || draw_we;
  assign ram_waddr = init_we ? step[AW-1:0] : slot_reg;

  smp_slot #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_slot (
    .last(last),
    .slot(slot_c)
  );

  smp_mulmod u_mulmod (
    .clk    (clk),
    .en     (mm_en),
    .operand(gen),
    .result (gen_step)
  );

  smp_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(gen_step),
    .re   (issue),
    .raddr(slot_c),
    .rdata(ram_rdata)
  );

  // Sequencer for initialization and draws.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = need_init ? S_INIT_MUL : S_DRAW_WR;
        end
      end
      S_INIT_MUL: begin
        state_next = S_INIT_FOLD;
      end
      S_INIT_FOLD: begin
        state_next = (step == '0) ? S_DRAW_RD : S_INIT_MUL;
      end
      S_DRAW_RD: begin
        state_next = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state: sequencer, generator value and last output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gen   <= WORD_W'(1);
      last  <= '0;
    end else begin
      state <= state_next;
      if (accept && need_init) begin
        gen <= operation ? seed_fix : ((gen == '0) ? WORD_W'(1) : gen);
      end
      if (state == S_INIT_FOLD) begin
        gen <= gen_step;
        if (step == '0) begin
          last <= gen_step;
        end
      end
      if (draw_we) begin
        gen  <= gen_step;
        last <= ram_rdata;
      end
    end
  end

  // Warm-up step counter and the slot of the draw in flight.
  always_ff @(posedge clk) begin
    if (accept && need_init) begin
      step <= SW'(STEPS - 1);
    end else if (state == S_INIT_FOLD) begin
      step <= step - SW'(1);
    end
    if (issue) begin
      slot_reg <= slot_c;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (draw_we) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw_we) begin
      value <= ram_rdata;
    end
  end

endmodule

FILE: hw/rtl/smp_checker.sv
// Port-level checker for the shuffled minimal-standard generator, with its bind.
`timescale 1ns / 1ps

module smp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_stall,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic [smp_pkg::WORD_W-1:0] value
);

  import smp_pkg::*;

  // A stalled result word holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(value))
    else $error("stalled result word changed");

  // Every result lies strictly between zero and the modulus.
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (value != '0) && (value != MODULUS))
    else $error("result word out of range");

  // An accepted word keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second word accepted back to back");

  // Reset leaves no result word pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word pending after reset");

endmodule

bind shuffled_minimal_standard_prng smp_checker u_smp_checker (.*);
